### src/ttq_pkg.sv
// shared types and constants of the tagged task queue
package ttq_pkg;

  localparam logic REQ_NOTE  = 1'b0;
  localparam logic REQ_CLAIM = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] task_addr;
    logic [31:0] return_context;
    logic [31:0] root_list;
    logic [31:0] microcode;
    logic [31:0] microcode_data;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] claimed_sequence;
    logic [31:0] claimed_task_addr;
    logic [31:0] claimed_context;
  } rsp_t;

  typedef struct packed {
    logic [63:0] seq_num;
    logic [31:0] task_addr;
    logic [31:0] return_context;
    logic [31:0] root_list;
    logic [31:0] microcode;
    logic [31:0] microcode_data;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic note;       // append the request beat as a record
    logic start;      // latch claim keys and rewind the scan
    logic scan;       // scan in progress
    logic take_hit;   // capture the matched record, drop it and older ones
    logic take_miss;  // capture a not-found result
    logic load_out;   // move the captured result into the output register
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } status_t;

endpackage

### src/ttq_if.sv
// request and response channel interfaces
interface ttq_req_if import ttq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttq_rsp_if import ttq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/ttq_ctrl.sv
// controller state machine of the tagged task queue
module ttq_ctrl import ttq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  input  logic    req_type_i,
  output logic    req_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && (req_type_i == REQ_CLAIM)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.hit || status_i.scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.note   = req_valid_i && (req_type_i == REQ_NOTE);
        cmd_o.start  = req_valid_i && (req_type_i == REQ_CLAIM);
      end
      ST_SCAN: begin
        cmd_o.scan      = 1'b1;
        cmd_o.take_hit  = status_i.hit;
        cmd_o.take_miss = !status_i.hit && status_i.scan_end;
      end
      ST_DONE: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

### src/ttq_dp.sv
// datapath: record memory, queue pointers, scan pipeline and output register
module ttq_dp import ttq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_data_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  logic    rsp_ready_i,
  output logic    rsp_valid_o,
  output rsp_t    rsp_data_o
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(QUEUE_DEPTH);

  rec_t mem [QUEUE_DEPTH];

  logic [IW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] count_q, count_d;
  logic [63:0]   seq_q, seq_d;
  logic [CW-1:0] issued_q, issued_d;
  logic          cmp_v_q, cmp_v_d;
  logic          rsp_valid_q, rsp_valid_d;

  logic [IW-1:0] ptr_q;
  logic [IW-1:0] cmp_pos_q;
  logic [CW-1:0] cmp_off_q;
  logic [31:0]   key_root_q, key_mc_q, key_mcd_q;
  rec_t          rd_rec_q;
  rsp_t          res_q;
  rsp_t          rsp_q;

  logic          full;
  logic [CW:0]   tail_sum;
  logic [CW:0]   tail_wrap;
  logic [IW-1:0] wr_pos;
  logic          match;
  logic          more;
  logic          issue;
  rec_t          wr_rec;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + IW'(1);
  endfunction

  assign full      = (count_q == DEPTH_CNT);
  assign tail_sum  = (CW + 1)'(oldest_q) + (CW + 1)'(count_q);
  assign tail_wrap = (tail_sum >= DEPTH_EXT) ? tail_sum - DEPTH_EXT : tail_sum;
  assign wr_pos    = full ? oldest_q : tail_wrap[IW-1:0];

  assign wr_rec = '{seq_num:        seq_q,
                    task_addr:      req_data_i.task_addr,
                    return_context: req_data_i.return_context,
                    root_list:      req_data_i.root_list,
                    microcode:      req_data_i.microcode,
                    microcode_data: req_data_i.microcode_data};

  // compare stage looks at the record read in the previous cycle
  assign match = cmp_v_q && (rd_rec_q.root_list == key_root_q) &&
                 (rd_rec_q.microcode == key_mc_q) &&
                 (rd_rec_q.microcode_data == key_mcd_q);
  assign more  = (issued_q < count_q);
  assign issue = cmd_i.scan && !match && more;

  assign status_o.hit      = match;
  assign status_o.scan_end = !more && !cmp_v_q;
  assign status_o.out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    oldest_d    = oldest_q;
    count_d     = count_q;
    seq_d       = seq_q;
    issued_d    = issued_q;
    cmp_v_d     = cmp_v_q;
    rsp_valid_d = rsp_valid_q;
    if (cmd_i.note) begin
      seq_d = seq_q + 64'd1;
      if (full) begin
        oldest_d = next_idx(oldest_q);
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.start) begin
      issued_d = '0;
      cmp_v_d  = 1'b0;
    end
    if (cmd_i.scan) begin
      cmp_v_d = issue;
      if (issue) begin
        issued_d = issued_q + CW'(1);
      end
    end
    if (cmd_i.take_hit) begin
      oldest_d = next_idx(cmp_pos_q);
      count_d  = count_q - (cmp_off_q + CW'(1));
    end
    if (cmd_i.load_out) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      count_q     <= '0;
      seq_q       <= 64'd1;
      issued_q    <= '0;
      cmp_v_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      seq_q       <= seq_d;
      issued_q    <= issued_d;
      cmp_v_q     <= cmp_v_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ptr_q      <= oldest_q;
      key_root_q <= req_data_i.root_list;
      key_mc_q   <= req_data_i.microcode;
      key_mcd_q  <= req_data_i.microcode_data;
    end
    if (issue) begin
      ptr_q     <= next_idx(ptr_q);
      cmp_pos_q <= ptr_q;
      cmp_off_q <= issued_q;
    end
    if (cmd_i.take_hit) begin
      res_q <= '{found:             1'b1,
                 claimed_sequence:  rd_rec_q.seq_num,
                 claimed_task_addr: rd_rec_q.task_addr,
                 claimed_context:   rd_rec_q.return_context};
    end else if (cmd_i.take_miss) begin
      res_q <= '0;
    end
    if (cmd_i.load_out) begin
      rsp_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.note) begin
      mem[wr_pos] <= wr_rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_rec_q <= mem[ptr_q];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("held count above queue depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> issued_q <= count_q)
    else $error("scan issued past the held records");

  a_hit_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_hit |-> cmp_off_q < count_q)
    else $error("matched offset outside held records");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.note |=> seq_q == $past(seq_q) + 64'd1)
    else $error("sequence counter did not advance on note");

endmodule

### src/tagged_task_queue_claim.sv
// note: written at the accepting edge; one note per cycle while no claim is in progress.
// claim: one memory read per cycle from oldest to newest plus one compare stage; a match
//   is captured into the result register, and a miss once every held record is compared;
// a claim holds the request channel until its result loads into the free output register.
// reset clears the oldest pointer, the held count and the output valid flag and sets the
//   sequence counter to one; record memory is not cleared, only held entries are read.
module tagged_task_queue_claim import ttq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttq_req_if.sink    req_i,
  ttq_rsp_if.source  rsp_o
);

  cmd_t    cmd;
  status_t status;
  logic    req_ready;

  ttq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.data.req_type),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ttq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_data_o  (rsp_o.data)
  );

  assign req_i.ready = req_ready;

endmodule
